// ===== src/load_to_frequency_step_picker_assert.svh =====
// Assertion macros shared by the scan logic.
`ifndef LOAD_TO_FREQUENCY_STEP_PICKER_ASSERT_SVH
`define LOAD_TO_FREQUENCY_STEP_PICKER_ASSERT_SVH

// same-cycle implication
`define LFSP_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LFSP_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/lfsp_pkg.sv =====
`default_nettype none

package lfsp_pkg;

    localparam int FREQ_ENTRIES = 16;
    localparam int FREQ_BITS    = 22;
    localparam int INDEX_BITS   = 4;
    localparam int LOAD_BITS    = 7;
    localparam int TLEN_BITS    = 5;
    localparam int LEFT_BITS    = $clog2(FREQ_ENTRIES + 1);

    localparam int ADDR_BITS = 4;
    localparam int DATA_BITS = 32;
    localparam int REG_BITS  = ADDR_BITS - 2;

    localparam logic [REG_BITS-1:0] REG_MIN_KHZ  = REG_BITS'(0);
    localparam logic [REG_BITS-1:0] REG_MAX_KHZ  = REG_BITS'(1);
    localparam logic [REG_BITS-1:0] REG_TABLE_LEN = REG_BITS'(2);

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    // max/100 = (max/4)/25, reciprocal multiply exact over the whole range
    localparam int QIN_BITS  = FREQ_BITS - 2;
    localparam int QMUL_BITS = FREQ_BITS - 1;
    localparam int QSHIFT    = FREQ_BITS + 3;
    localparam int QP_BITS   = QIN_BITS + QMUL_BITS;
    localparam int QUOT_BITS = QP_BITS - QSHIFT;
    localparam int PROD_BITS = LOAD_BITS + QUOT_BITS;
    localparam logic [QMUL_BITS-1:0] QMUL =
        QMUL_BITS'(((64'd1 << QSHIFT) + 64'd24) / 64'd25);

    typedef struct packed {
        logic                  op;
        logic [INDEX_BITS-1:0] entry_index;
        logic [FREQ_BITS-1:0]  entry_khz;
        logic                  entry_valid;
        logic [LOAD_BITS-1:0]  load_percent;
        logic [FREQ_BITS-1:0]  current_khz;
    } t_in_item;

    typedef struct packed {
        logic [FREQ_BITS-1:0] target_khz;
        logic                 change_request;
    } t_out_item;

    typedef struct packed {
        logic [FREQ_BITS-1:0] min_khz;
        logic [FREQ_BITS-1:0] max_khz;
        logic [TLEN_BITS-1:0] table_length;
    } t_cfg;

    typedef struct packed {
        logic                 we;
        logic [FREQ_BITS-1:0] khz;
        logic                 valid;
    } t_entry_wr;

    typedef struct packed {
        logic                 vld;
        logic [LEFT_BITS-1:0] left;
        logic [FREQ_BITS-1:0] want;
        logic [FREQ_BITS-1:0] below;
        logic [FREQ_BITS-1:0] above;
        logic                 exact;
        logic                 done;
    } t_scan_pkt;

endpackage

`default_nettype wire

// ===== src/lfsp_apb_regs.sv =====
`default_nettype none

module lfsp_apb_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lfsp_pkg::ADDR_BITS-1:0] paddr,
    input  logic [lfsp_pkg::DATA_BITS-1:0] pwdata,
    output logic [lfsp_pkg::DATA_BITS-1:0] prdata,
    output logic                          pready,
    output lfsp_pkg::t_cfg                o_cfg
);
    import lfsp_pkg::*;

    t_cfg                r_cfg;
    t_cfg                n_cfg;
    logic [REG_BITS-1:0] w_reg;

    assign w_reg  = paddr[ADDR_BITS-1:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (psel && penable && pwrite) begin
            case (w_reg)
                REG_MIN_KHZ:   n_cfg.min_khz      = pwdata[FREQ_BITS-1:0];
                REG_MAX_KHZ:   n_cfg.max_khz      = pwdata[FREQ_BITS-1:0];
                REG_TABLE_LEN: n_cfg.table_length = pwdata[TLEN_BITS-1:0];
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            REG_MIN_KHZ:   prdata = DATA_BITS'(r_cfg.min_khz);
            REG_MAX_KHZ:   prdata = DATA_BITS'(r_cfg.max_khz);
            REG_TABLE_LEN: prdata = DATA_BITS'(r_cfg.table_length);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_khz      <= '0;
            r_cfg.max_khz      <= '1;
            r_cfg.table_length <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

// ===== src/lfsp_cell.sv =====
`default_nettype none

`include "load_to_frequency_step_picker_assert.svh"

module lfsp_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lfsp_pkg::t_entry_wr  i_wr,
    input  lfsp_pkg::t_scan_pkt  i_pkt,
    output lfsp_pkg::t_scan_pkt  o_pkt
);
    import lfsp_pkg::*;

    logic [FREQ_BITS-1:0] r_khz;
    logic                 r_valid;
    t_scan_pkt            r_pkt;
    t_scan_pkt            n_pkt;

    always_comb begin
        n_pkt = i_pkt;
        if (i_pkt.vld && (i_pkt.left != '0)) begin
            n_pkt.left = i_pkt.left - LEFT_BITS'(1);
            if (!i_pkt.done && r_valid) begin
                if (r_khz < i_pkt.want) begin
                    n_pkt.below = r_khz;
                end
                if (r_khz == i_pkt.want) begin
                    n_pkt.exact = 1'b1;
                    n_pkt.done  = 1'b1;
                end
                if (r_khz > i_pkt.want) begin
                    n_pkt.above = r_khz;
                    n_pkt.done  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_khz <= i_wr.khz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pkt   <= '0;
        end else begin
            if (i_wr.we) begin
                r_valid <= i_wr.valid;
            end
            r_pkt <= n_pkt;
        end
    end

    assign o_pkt = r_pkt;

    `LFSP_ASSERT_NXT(a_done_sticks, i_pkt.vld && i_pkt.done, o_pkt.vld && o_pkt.done, "scan result lost in cell")
    `LFSP_ASSERT_NXT(a_left_counts, i_pkt.vld && (i_pkt.left != '0), o_pkt.left == $past(i_pkt.left) - LEFT_BITS'(1), "slot count not decremented")

endmodule

`default_nettype wire

// ===== src/load_to_frequency_step_picker.sv =====
// Channel   Dir  Handshake                Payload
// input     in   i_in_valid / o_in_ready  i_in_data  (t_in_item)
// output    out  o_out_valid / i_out_ready o_out_data (t_out_item)
// config    in   psel & penable & pwrite  paddr, pwdata, prdata (pready tied high)
//
// Write item: no result; ready stays high for the next item.
// Sample item: divide, multiply, clamp, launch, then a pass through the 16-cell chain;
//   ready stays low until the result moves into the output register.
// Synchronous active-low reset clears all valid marks, zeroes min_khz and table_length, and sets max_khz to all ones.
// A result waiting on o_out_valid holds the next sample in its last state, not its transfer.
`default_nettype none

`include "load_to_frequency_step_picker_assert.svh"

module load_to_frequency_step_picker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  lfsp_pkg::t_in_item             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output lfsp_pkg::t_out_item            o_out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lfsp_pkg::ADDR_BITS-1:0] paddr,
    input  logic [lfsp_pkg::DATA_BITS-1:0] pwdata,
    output logic [lfsp_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready
);
    import lfsp_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_QUOT   = 3'd1;
    localparam logic [2:0] ST_PROD   = 3'd2;
    localparam logic [2:0] ST_CLAMP  = 3'd3;
    localparam logic [2:0] ST_LAUNCH = 3'd4;
    localparam logic [2:0] ST_SCAN   = 3'd5;
    localparam logic [2:0] ST_RESULT = 3'd6;

    t_cfg                  w_cfg;
    logic [2:0]            r_state;
    logic [2:0]            n_state;
    logic                  w_in_acc;
    logic                  w_out_free;
    logic                  r_out_vld;
    logic                  n_out_vld;
    t_out_item             r_out;
    t_out_item             r_res;
    t_out_item             w_res;
    logic [LOAD_BITS-1:0]  r_load;
    logic [FREQ_BITS-1:0]  r_cur;
    logic [QP_BITS-1:0]    w_qprod;
    logic [QUOT_BITS-1:0]  r_quot;
    logic [PROD_BITS-1:0]  r_prod;
    logic [PROD_BITS-1:0]  w_lo;
    logic [PROD_BITS-1:0]  w_hi;
    logic [FREQ_BITS-1:0]  r_want;
    logic [LEFT_BITS-1:0]  w_nscan;
    t_scan_pkt             w_pkt [FREQ_ENTRIES+1];
    t_scan_pkt             w_tail;
    logic [FREQ_ENTRIES-1:0] w_chain_vld;

    lfsp_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_vld || i_out_ready;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    assign w_qprod = QP_BITS'(w_cfg.max_khz[FREQ_BITS-1:2]) * QP_BITS'(QMUL);

    assign w_lo = (r_prod < PROD_BITS'(w_cfg.min_khz)) ? PROD_BITS'(w_cfg.min_khz) : r_prod;
    assign w_hi = (w_lo > PROD_BITS'(w_cfg.max_khz)) ? PROD_BITS'(w_cfg.max_khz) : w_lo;

    assign w_nscan = (32'(w_cfg.table_length) > FREQ_ENTRIES) ?
                     LEFT_BITS'(FREQ_ENTRIES) : LEFT_BITS'(w_cfg.table_length);

    always_comb begin
        w_pkt[0]       = '0;
        w_pkt[0].vld   = (r_state == ST_LAUNCH);
        w_pkt[0].left  = w_nscan;
        w_pkt[0].want  = r_want;
    end

    genvar g;
    generate
        for (g = 0; g < FREQ_ENTRIES; g++) begin : g_cell
            t_entry_wr w_wr;
            assign w_wr.we    = w_in_acc && (i_in_data.op == OP_WRITE) &&
                                (32'(i_in_data.entry_index) == g);
            assign w_wr.khz   = i_in_data.entry_khz;
            assign w_wr.valid = i_in_data.entry_valid;
            assign w_chain_vld[g] = w_pkt[g+1].vld;

            lfsp_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_wr    (w_wr),
                .i_pkt   (w_pkt[g]),
                .o_pkt   (w_pkt[g+1])
            );
        end
    endgenerate

    assign w_tail = w_pkt[FREQ_ENTRIES];

    always_comb begin
        if (w_tail.exact && (w_tail.want != '0)) begin
            w_res.target_khz = w_tail.want;
        end else if ((r_cur >= w_tail.below) && (r_cur <= w_tail.above)) begin
            w_res.target_khz = r_cur;
        end else begin
            w_res.target_khz = w_tail.above;
        end
        w_res.change_request = (w_res.target_khz != '0) && (w_res.target_khz != r_cur);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && (i_in_data.op == OP_SAMPLE)) begin
                    n_state = ST_QUOT;
                end
            end
            ST_QUOT:   n_state = ST_PROD;
            ST_PROD:   n_state = ST_CLAMP;
            ST_CLAMP:  n_state = ST_LAUNCH;
            ST_LAUNCH: n_state = ST_SCAN;
            ST_SCAN: begin
                if (w_tail.vld) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if ((r_state == ST_RESULT) && w_out_free) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_load <= i_in_data.load_percent;
            r_cur  <= i_in_data.current_khz;
        end
        if (r_state == ST_QUOT) begin
            r_quot <= w_qprod[QP_BITS-1:QSHIFT];
        end
        if (r_state == ST_PROD) begin
            r_prod <= PROD_BITS'(r_load) * PROD_BITS'(r_quot);
        end
        if (r_state == ST_CLAMP) begin
            r_want <= w_hi[FREQ_BITS-1:0];
        end
        if ((r_state == ST_SCAN) && w_tail.vld) begin
            r_res <= w_res;
        end
        if ((r_state == ST_RESULT) && w_out_free) begin
            r_out <= r_res;
        end
    end

    `LFSP_ASSERT_IMP(a_one_scan, 1'b1, $countones(w_chain_vld) <= 1, "more than one scan in the chain")
    `LFSP_ASSERT_IMP(a_tail_in_scan, w_tail.vld, r_state == ST_SCAN, "scan ended outside scan state")
    `LFSP_ASSERT_NXT(a_sample_start, w_in_acc && (i_in_data.op == OP_SAMPLE), r_state == ST_QUOT, "sample transfer did not start")
    `LFSP_ASSERT_IMP(a_change_nonzero, o_out_valid && o_out_data.change_request, o_out_data.target_khz != '0, "change requested for zero target")

endmodule

`default_nettype wire

// ===== verif/load_to_frequency_step_picker_tb.sv =====
`timescale 1ns / 1ps

module load_to_frequency_step_picker_tb;
    import lfsp_pkg::*;

    localparam int IN_W = $bits(t_in_item);
    localparam logic [FREQ_BITS-1:0] KHZ_TOP = '1;
    localparam int HOLD_CYCLES = 600;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    t_in_item             i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_item            o_out_data;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [DATA_BITS-1:0] pwdata = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    load_to_frequency_step_picker dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #5 i_clk = ~i_clk;

    // governor state mirror
    logic [FREQ_BITS-1:0] slot_khz [FREQ_ENTRIES];
    logic                 slot_valid [FREQ_ENTRIES];
    logic [FREQ_BITS-1:0] lim_min;
    logic [FREQ_BITS-1:0] lim_max;
    logic [TLEN_BITS-1:0] scan_len;

    t_in_item             governor_items [$];
    t_out_item            expected_picks [$];
    logic [FREQ_BITS-1:0] planned_khz [$];
    t_out_item            oldest_pick;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_request = 1'b0;
    bit hold_taken = 1'b0;
    int hold_left = 0;
    int errors = 0;
    int writes_sent = 0;
    int samples_sent = 0;
    int results_seen = 0;
    int phases_run = 0;

    int send_mode [4] = '{0, 79, 0, 32};
    int recv_mode [4] = '{0, 0, 79, 32};

    function automatic t_out_item pick_frequency(t_in_item it);
        t_out_item            r;
        logic [63:0]          want;
        logic [FREQ_BITS-1:0] below;
        logic [FREQ_BITS-1:0] above;
        logic [FREQ_BITS-1:0] target;
        logic                 exact;
        int                   n;
        below = '0;
        above = '0;
        target = '0;
        exact = 1'b0;
        want = 64'(it.load_percent) * 64'(lim_max / 100);
        if (want < 64'(lim_min)) want = 64'(lim_min);
        if (want > 64'(lim_max)) want = 64'(lim_max);
        n = (int'(scan_len) > FREQ_ENTRIES) ? FREQ_ENTRIES : int'(scan_len);
        for (int s = 0; s < n; s++) begin
            if (slot_valid[s]) begin
                if (64'(slot_khz[s]) < want) begin
                    below = slot_khz[s];
                end else if (64'(slot_khz[s]) == want) begin
                    target = slot_khz[s];
                    exact = 1'b1;
                    break;
                end else begin
                    above = slot_khz[s];
                    break;
                end
            end
        end
        if (!exact || target == '0) begin
            if (it.current_khz >= below && it.current_khz <= above) target = it.current_khz;
            else target = above;
        end
        r.target_khz = target;
        r.change_request = (target != '0) && (target != it.current_khz);
        return r;
    endfunction

    function automatic t_in_item noise_item();
        return t_in_item'(IN_W'({$urandom, $urandom}));
    endfunction

    function automatic t_in_item write_item(input logic [INDEX_BITS-1:0] slot,
                                            input logic [FREQ_BITS-1:0] khz,
                                            input logic ok);
        t_in_item it;
        it = noise_item();
        it.op = OP_WRITE;
        it.entry_index = slot;
        it.entry_khz = khz;
        it.entry_valid = ok;
        return it;
    endfunction

    function automatic t_in_item sample_item(input logic [LOAD_BITS-1:0] load,
                                             input logic [FREQ_BITS-1:0] cur);
        t_in_item it;
        it = noise_item();
        it.op = OP_SAMPLE;
        it.load_percent = load;
        it.current_khz = cur;
        return it;
    endfunction

    task automatic reg_write(input logic [REG_BITS-1:0] idx, input logic [DATA_BITS-1:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MIN_KHZ:   lim_min = val[FREQ_BITS-1:0];
            REG_MAX_KHZ:   lim_max = val[FREQ_BITS-1:0];
            REG_TABLE_LEN: scan_len = val[TLEN_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic set_limits(input logic [FREQ_BITS-1:0] lo, input logic [FREQ_BITS-1:0] hi,
                              input logic [TLEN_BITS-1:0] len);
        reg_write(REG_MIN_KHZ, DATA_BITS'(lo));
        reg_write(REG_MAX_KHZ, DATA_BITS'(hi));
        reg_write(REG_TABLE_LEN, DATA_BITS'(len));
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (governor_items.size() != 0 || i_in_valid || expected_picks.size() != 0);
        repeat (40) @(posedge i_clk);
        phases_run++;
    endtask

    task automatic random_phase(input int n_samples, input int send_pct, input int recv_pct);
        int                   k;
        int                   roll;
        bit                   grid;
        logic [FREQ_BITS-1:0] top;
        logic [FREQ_BITS-1:0] hi;
        logic [FREQ_BITS-1:0] lo;
        logic [TLEN_BITS-1:0] len;
        logic [FREQ_BITS-1:0] cur;
        logic [LOAD_BITS-1:0] load;
        k = $urandom_range(FREQ_ENTRIES);
        grid = ($urandom_range(4) < 2);
        hi = ($urandom_range(4) == 0) ? KHZ_TOP : FREQ_BITS'($urandom_range(100, int'(KHZ_TOP)));
        planned_khz.delete();
        repeat (k) begin
            if (grid) planned_khz.push_back(FREQ_BITS'((hi / 100) * $urandom_range(100)));
            else if ($urandom_range(19) == 0) planned_khz.push_back('0);
            else planned_khz.push_back(FREQ_BITS'($urandom));
        end
        planned_khz.sort();
        top = (k > 0) ? planned_khz[k-1] : '0;
        if (!grid && $urandom_range(1)) begin
            if (32'(top) + 2000 > 32'(KHZ_TOP)) hi = KHZ_TOP;
            else hi = top + FREQ_BITS'($urandom_range(2000));
        end
        roll = $urandom_range(9);
        if (roll < 5) lo = '0;
        else if (roll < 9) lo = FREQ_BITS'($urandom_range(int'(hi)));
        else lo = FREQ_BITS'($urandom);
        roll = $urandom_range(19);
        if (roll < 12) len = TLEN_BITS'(k);
        else if (roll < 16) len = TLEN_BITS'($urandom_range(31));
        else len = TLEN_BITS'(FREQ_ENTRIES + $urandom_range(15));
        set_limits(lo, hi, len);

        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        for (int s = 0; s < FREQ_ENTRIES; s++) begin
            if (s < k)
                governor_items.push_back(write_item(INDEX_BITS'(s), planned_khz[s],
                                                    $urandom_range(9) != 0));
            else
                governor_items.push_back(write_item(INDEX_BITS'(s), FREQ_BITS'($urandom),
                                                    $urandom_range(7) == 0));
        end
        repeat (n_samples) begin
            if ($urandom_range(39) == 0)
                governor_items.push_back(write_item(INDEX_BITS'($urandom), FREQ_BITS'($urandom),
                                                    1'($urandom)));
            roll = $urandom_range(19);
            if (k > 0 && roll < 7) cur = planned_khz[$urandom_range(k-1)];
            else if (k > 0 && roll < 10)
                cur = planned_khz[$urandom_range(k-1)] +
                      ($urandom_range(1) ? FREQ_BITS'(1) : KHZ_TOP);
            else if (roll < 13) cur = '0;
            else if (roll < 15) cur = KHZ_TOP;
            else cur = FREQ_BITS'($urandom);
            if ($urandom_range(9) < 7) load = LOAD_BITS'($urandom_range(100));
            else load = LOAD_BITS'($urandom_range(127));
            governor_items.push_back(sample_item(load, cur));
        end
        drain();
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                if (i_in_data.op == OP_WRITE) begin
                    slot_khz[i_in_data.entry_index] = i_in_data.entry_khz;
                    slot_valid[i_in_data.entry_index] = i_in_data.entry_valid;
                    writes_sent++;
                end else begin
                    expected_picks.push_back(pick_frequency(i_in_data));
                    samples_sent++;
                end
            end
            if (!i_in_valid || o_in_ready) begin
                if (governor_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_data <= governor_items.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_request && !hold_taken) begin
            hold_left <= HOLD_CYCLES;
            hold_taken <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_picks.size() == 0) begin
                    $display("%0t: unexpected transfer, expected none, actual %h",
                             $time, o_out_data);
                    errors++;
                end else begin
                    oldest_pick = expected_picks.pop_front();
                    results_seen++;
                    if (o_out_data.target_khz !== oldest_pick.target_khz) begin
                        $display("%0t: target_khz expected %0d actual %0d",
                                 $time, oldest_pick.target_khz, o_out_data.target_khz);
                        errors++;
                    end
                    if (o_out_data.change_request !== oldest_pick.change_request) begin
                        $display("%0t: change_request expected %b actual %b",
                                 $time, oldest_pick.change_request, o_out_data.change_request);
                        errors++;
                    end
                end
            end
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("%0t: timeout", $time);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        for (int s = 0; s < FREQ_ENTRIES; s++) begin
            slot_khz[s] = '0;
            slot_valid[s] = 1'b0;
        end
        lim_min = '0;
        lim_max = KHZ_TOP;
        scan_len = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // sparse ascending table, one hole, long table length
        set_limits(FREQ_BITS'(100000), FREQ_BITS'(2000000), TLEN_BITS'(20));
        governor_items.push_back(write_item(INDEX_BITS'(0), FREQ_BITS'(300000), 1'b1));
        governor_items.push_back(write_item(INDEX_BITS'(1), FREQ_BITS'(600000), 1'b1));
        governor_items.push_back(write_item(INDEX_BITS'(2), FREQ_BITS'(900000), 1'b0));
        governor_items.push_back(write_item(INDEX_BITS'(3), FREQ_BITS'(1200000), 1'b1));
        governor_items.push_back(write_item(INDEX_BITS'(4), FREQ_BITS'(2000000), 1'b1));
        governor_items.push_back(sample_item(LOAD_BITS'(0), '0));
        governor_items.push_back(sample_item(LOAD_BITS'(15), FREQ_BITS'(500000)));
        governor_items.push_back(sample_item(LOAD_BITS'(40), FREQ_BITS'(1000000)));
        governor_items.push_back(sample_item(LOAD_BITS'(40), FREQ_BITS'(500000)));
        governor_items.push_back(sample_item(LOAD_BITS'(100), FREQ_BITS'(2000000)));
        governor_items.push_back(sample_item(LOAD_BITS'(127), KHZ_TOP));
        governor_items.push_back(sample_item(LOAD_BITS'(55), FREQ_BITS'(1200000)));
        governor_items.push_back(sample_item(LOAD_BITS'(1), FREQ_BITS'(300000)));
        drain();

        // min above max, empty table
        set_limits(KHZ_TOP, '0, '0);
        governor_items.push_back(sample_item(LOAD_BITS'(0), '0));
        governor_items.push_back(sample_item(LOAD_BITS'(127), KHZ_TOP));
        governor_items.push_back(sample_item(LOAD_BITS'(100), FREQ_BITS'(12345)));
        drain();

        // zero-frequency exact hit, nothing above, top entry
        set_limits('0, KHZ_TOP, TLEN_BITS'(FREQ_ENTRIES));
        governor_items.push_back(write_item(INDEX_BITS'(0), '0, 1'b1));
        governor_items.push_back(sample_item(LOAD_BITS'(0), FREQ_BITS'(5)));
        governor_items.push_back(sample_item(LOAD_BITS'(100), '0));
        governor_items.push_back(write_item(INDEX_BITS'(15), KHZ_TOP, 1'b1));
        governor_items.push_back(sample_item(LOAD_BITS'(100), FREQ_BITS'(3000000)));
        drain();

        for (int p = 0; p < 8; p++) begin
            if (p == 4) hold_request = 1'b1;
            random_phase(180, send_mode[p % 4], recv_mode[p % 4]);
        end

        repeat (50) @(posedge i_clk);
        if (expected_picks.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_picks.size());
            errors++;
        end
        $display("Covered %0d table writes and %0d load samples in %0d phases, %0d results checked",
                 writes_sent, samples_sent, phases_run, results_seen);
        $display("with idle and stall mixes plus one long output hold-off; %0d errors", errors);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
